// ===== rtl/core/scanned_dac_serial_frame_driver_defines.svh =====
// Assertion macros shared by the scanned DAC serial frame driver RTL.
// Included by the top level; depends on nothing else.
`ifndef SCANNED_DAC_SERIAL_FRAME_DRIVER_DEFINES_SVH
`define SCANNED_DAC_SERIAL_FRAME_DRIVER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SDSFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdsfd same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SDSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdsfd next-cycle check failed");

`endif

// ===== rtl/core/sdsfd_pkg.sv =====
// Package for the scanned DAC serial frame driver: codes, widths and constants.
// No dependencies.
`timescale 1ns / 1ps

package sdsfd_pkg;

  // Stream and register port widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;

  localparam int DEF_NUM_CHANNELS = 4;

  // Item kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Register indexes on the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_VARIANT = 3'd0,
    REG_OFFSET0 = 3'd1,
    REG_OFFSET1 = 3'd2,
    REG_OFFSET2 = 3'd3,
    REG_OFFSET3 = 3'd4
  } reg_idx_t;

  localparam logic [7:0]  OFFSET_RESET = 8'd128;
  localparam logic [16:0] SUM_BIAS     = 17'd128;
  localparam logic [16:0] CLAMP_10BIT  = 17'h003FF;
  localparam logic [16:0] CLAMP_8BIT   = 17'h000FF;
  localparam logic [5:0]  FRAME_TICKS_V1 = 6'd32;
  localparam logic [5:0]  FRAME_TICKS_V0 = 6'd22;
  localparam int          MSB_BIT_V1 = 15;
  localparam int          MSB_BIT_V0 = 10;

  // Channel code placed in the DAC address bits of a frame.
  function automatic logic [1:0] chan_code(input logic [1:0] ch);
    logic [1:0] code;
    case (ch)
      2'd0:    code = 2'd3;
      2'd1:    code = 2'd0;
      2'd2:    code = 2'd1;
      default: code = 2'd2;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/scanned_dac_serial_frame_driver.sv =====
// Top level of the scanned DAC serial frame driver: stream in, pins and reads out, APB setup.
// Depends on sdsfd_pkg and scanned_dac_serial_frame_driver_defines.svh.
//
//  Channel | Direction | Fields
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | tdata: mode[1:0], channel[3:2], value[19:4]
//  out_    | master    | tdata: clock_pin[0], data_pin[1], frame_pin[2], read_value[18:3]
//  cfg_    | APB slave | variant @0x00, offset_ch0..3 @0x04..0x10
//
// Each item passes through two registers from acceptance to result: the input register and
// the output register. A new item is accepted every cycle while the output is not stalled;
// the pin and scan state is updated in the single step between the two registers.
// Reset is synchronous and active low; pins come up as clock 0, data 0, frame 1.
// A stalled output holds the result; the input register still takes one more transaction.
`timescale 1ns / 1ps
`include "scanned_dac_serial_frame_driver_defines.svh"

module scanned_dac_serial_frame_driver #(
  parameter int NUM_CHANNELS = sdsfd_pkg::DEF_NUM_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [sdsfd_pkg::IN_TDATA_W-1:0]      in_tdata,   // mode, channel, value, zero pad
  // Result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [sdsfd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // clock, data, frame, read_value, pad
  // Configuration port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [sdsfd_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  logic [sdsfd_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic [sdsfd_pkg::APB_DATA_W-1:0]      cfg_prdata,
  output logic                                  cfg_pready
);

  import sdsfd_pkg::*;

  localparam int CH_W = $clog2(NUM_CHANNELS);

  // Configuration registers.
  logic       variant_r;
  logic [7:0] offset_r [4];

  // Input register.
  logic        s1_valid_r;
  mode_t       s1_mode_r;
  logic [1:0]  s1_channel_r;
  logic [15:0] s1_value_r;

  // Scan and pin state.
  logic [5:0]      step_r, step_nxt;
  logic [CH_W-1:0] next_ch_r, next_ch_nxt;
  logic [15:0]     shift_r, shift_nxt;
  logic [15:0]     cv_r [NUM_CHANNELS];
  logic            pin_clk_r, pin_clk_nxt;
  logic            pin_dat_r, pin_dat_nxt;
  logic            pin_frm_r, pin_frm_nxt;

  // Output register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                 out_free;
  logic                 advance;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 ch_in_range;
  logic [CH_W-1:0]      cv_idx;
  logic [15:0]          cv_rd;
  logic [1:0]           off_idx;
  logic [16:0]          sum;
  logic [16:0]          biased;
  logic [15:0]          frame_word;
  logic [15:0]          cur_word;
  logic [5:0]           limit;
  logic [15:0]          rd_nxt;

  // Handshake: the input register moves on whenever the output register is free.
  assign out_free   = !out_valid_r || out_tready;
  assign advance    = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // APB register access.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
      for (int i = 0; i < 4; i++) offset_r[i] <= OFFSET_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_idx))
        REG_VARIANT: variant_r   <= cfg_pwdata[0];
        REG_OFFSET0: offset_r[0] <= cfg_pwdata[7:0];
        REG_OFFSET1: offset_r[1] <= cfg_pwdata[7:0];
        REG_OFFSET2: offset_r[2] <= cfg_pwdata[7:0];
        REG_OFFSET3: offset_r[3] <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_idx))
      REG_VARIANT: cfg_prdata = {31'd0, variant_r};
      REG_OFFSET0: cfg_prdata = {24'd0, offset_r[0]};
      REG_OFFSET1: cfg_prdata = {24'd0, offset_r[1]};
      REG_OFFSET2: cfg_prdata = {24'd0, offset_r[2]};
      REG_OFFSET3: cfg_prdata = {24'd0, offset_r[3]};
      default:     cfg_prdata = '0;
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r    <= mode_t'(in_tdata[1:0]);
      s1_channel_r <= in_tdata[3:2];
      s1_value_r   <= in_tdata[19:4];
    end
  end

  // One read of the channel values: the scan channel for ticks, else the addressed one.
  assign ch_in_range = ({1'b0, s1_channel_r} < 3'(NUM_CHANNELS));
  assign cv_idx      = (s1_mode_r == MODE_TICK) ? next_ch_r : s1_channel_r[CH_W-1:0];
  assign cv_rd       = cv_r[cv_idx];
  assign off_idx     = 2'(next_ch_r);

  // Frame word: offset sum, bias removal, clamp and channel code.
  always_comb begin
    sum    = {9'd0, offset_r[off_idx]} + {1'b0, cv_rd};
    biased = (sum > SUM_BIAS) ? (sum - SUM_BIAS) : '0;
    if (variant_r) begin
      frame_word = {chan_code(off_idx), 2'b00,
                    (biased > CLAMP_10BIT) ? CLAMP_10BIT[9:0] : biased[9:0], 2'b00};
    end else begin
      frame_word = {5'd0, chan_code(off_idx), 1'b0,
                    (biased > CLAMP_8BIT) ? CLAMP_8BIT[7:0] : biased[7:0]};
    end
  end

  // Tick sequencing: bit ticks alternate data-and-clock with clock return, then a closing tick.
  always_comb begin
    step_nxt    = step_r;
    next_ch_nxt = next_ch_r;
    shift_nxt   = shift_r;
    pin_clk_nxt = pin_clk_r;
    pin_dat_nxt = pin_dat_r;
    pin_frm_nxt = pin_frm_r;
    limit       = variant_r ? FRAME_TICKS_V1 : FRAME_TICKS_V0;
    cur_word    = (step_r == '0) ? frame_word : shift_r;
    if (step_r < limit) begin
      if (step_r[0]) begin
        pin_clk_nxt = variant_r;
      end else begin
        if (step_r == '0) begin
          next_ch_nxt = (next_ch_r == CH_W'(NUM_CHANNELS - 1)) ? '0 : next_ch_r + 1'b1;
          pin_frm_nxt = 1'b1;
        end
        pin_dat_nxt = (variant_r ? cur_word[MSB_BIT_V1] : cur_word[MSB_BIT_V0]) ^ variant_r;
        shift_nxt   = {cur_word[14:0], 1'b0};
        pin_clk_nxt = !variant_r;
      end
      step_nxt = step_r + 6'd1;
    end else begin
      pin_frm_nxt = 1'b0;
      pin_clk_nxt = 1'b0;
      step_nxt    = '0;
    end
  end

  // Read data for read items, scaled to the current variant.
  always_comb begin
    rd_nxt = '0;
    if (s1_mode_r == MODE_READ && ch_in_range) begin
      rd_nxt = variant_r ? cv_rd : {cv_rd[13:0], 2'b00};
    end
  end

  // State update as each item passes to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      next_ch_r <= '0;
      shift_r   <= '0;
      pin_clk_r <= 1'b0;
      pin_dat_r <= 1'b0;
      pin_frm_r <= 1'b1;
      for (int i = 0; i < NUM_CHANNELS; i++) cv_r[i] <= '0;
    end else if (advance) begin
      case (s1_mode_r)
        MODE_TICK: begin
          step_r    <= step_nxt;
          next_ch_r <= next_ch_nxt;
          shift_r   <= shift_nxt;
          pin_clk_r <= pin_clk_nxt;
          pin_dat_r <= pin_dat_nxt;
          pin_frm_r <= pin_frm_nxt;
        end
        MODE_WRITE: begin
          if (ch_in_range) begin
            cv_r[s1_channel_r[CH_W-1:0]] <= variant_r ? s1_value_r : {2'b00, s1_value_r[15:2]};
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_mode_r == MODE_TICK) begin
        out_tdata_r <= {5'd0, rd_nxt, pin_frm_nxt, pin_dat_nxt, pin_clk_nxt};
      end else begin
        out_tdata_r <= {5'd0, rd_nxt, pin_frm_r, pin_dat_r, pin_clk_r};
      end
    end
  end

  // Checks on the scan state.
  `SDSFD_ASSERT_NOW(a_step_bound, clk, rst_n, 1'b1, step_r <= FRAME_TICKS_V1)
  `SDSFD_ASSERT_NOW(a_chan_bound, clk, rst_n, 1'b1, {1'b0, next_ch_r} < (CH_W+1)'(NUM_CHANNELS))
  `SDSFD_ASSERT_NEXT(a_frame_start, clk, rst_n,
                     advance && s1_mode_r == MODE_TICK && step_r == '0, pin_frm_r)

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the scanned DAC serial frame driver.
// It needs sdsfd_pkg and the scanned_dac_serial_frame_driver RTL, and nothing else.
`timescale 1ns / 1ps

module tb;
  import sdsfd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 108;
  localparam int NUM_DIRECTED = 24;

  // One result transaction, laid out as out_tdata[18:0] (clock pin in bit 0).
  typedef struct packed {
    logic [15:0] read_value;
    logic        frame_pin;
    logic        data_pin;
    logic        clock_pin;
  } dac_result_t;

  // One directed stimulus row; the result is typed in only where fixed is set.
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  chan;
    logic [15:0] value;
    logic        fixed;
    dac_result_t want;
  } stim_row_t;

  // After reset in variant 0 the pins are clock 0, data 0, frame 1.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{MODE_READ,  2'd0, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
    '{MODE_NONE,  2'd3, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
    '{MODE_WRITE, 2'd1, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
    '{MODE_READ,  2'd1, 16'h0000, 1'b1, '{16'hFFFC, 1'b1, 1'b0, 1'b0}},
    '{MODE_WRITE, 2'd3, 16'h8001, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
    '{MODE_READ,  2'd3, 16'hFFFF, 1'b1, '{16'h8000, 1'b1, 1'b0, 1'b0}},
    '{MODE_WRITE, 2'd2, 16'h0003, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
    '{MODE_READ,  2'd2, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
    // First frame: channel 0 at zero level, so the word is just channel code 3.
    '{MODE_TICK,  2'd0, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b1}},
    '{MODE_TICK,  2'd3, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b0}},
    '{MODE_TICK,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_WRITE, 2'd0, 16'hFFFF, 1'b0, '0},
    '{MODE_READ,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_TICK,  2'd1, 16'h1234, 1'b0, '0},
    '{MODE_TICK,  2'd2, 16'h0000, 1'b0, '0},
    '{MODE_TICK,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_NONE,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_TICK,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_TICK,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_WRITE, 2'd1, 16'h0000, 1'b0, '0},
    '{MODE_TICK,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_TICK,  2'd0, 16'h0000, 1'b0, '0},
    '{MODE_READ,  2'd1, 16'h0000, 1'b0, '0},
    '{MODE_TICK,  2'd0, 16'h0000, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // mode[1:0], channel[3:2], value[19:4], pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // clock[0], data[1], frame[2], read_value[18:3], pad
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  cfg_paddr = '0;
  logic [APB_DATA_W-1:0]  cfg_pwdata = '0;
  logic [APB_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // Predicted state of the driver.
  logic        dac_variant;
  logic [7:0]  dac_offset [4];
  logic [15:0] stored_value [4];
  logic [5:0]  frame_step;
  logic [1:0]  scan_channel;
  logic [15:0] frame_shift;
  logic        pin_clock, pin_data, pin_frame;

  dac_result_t pending_results [$];
  int          error_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          frames_started = 0;
  int          cycle_count = 0;
  int          src_gap_pct = 0;
  int          sink_stall_pct = 0;
  int          stall_left = 0;

  scanned_dac_serial_frame_driver uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Result sink with random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin
    dac_result_t got;
    dac_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[18:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %h", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.clock_pin !== want.clock_pin) begin
          $error("clock_pin expected %0d got %0d", want.clock_pin, got.clock_pin);
          error_count++;
        end
        if (got.data_pin !== want.data_pin) begin
          $error("data_pin expected %0d got %0d", want.data_pin, got.data_pin);
          error_count++;
        end
        if (got.frame_pin !== want.frame_pin) begin
          $error("frame_pin expected %0d got %0d", want.frame_pin, got.frame_pin);
          error_count++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value expected %h got %h", want.read_value, got.read_value);
          error_count++;
        end
      end
    end
  end

  // Serial word for one channel: biased, clamped level with the channel code on top.
  function automatic logic [15:0] frame_word(input logic [1:0] ch);
    int unsigned level;
    logic [1:0]  code;
    code  = ch + 2'd3;
    level = 32'(dac_offset[ch]) + 32'(stored_value[ch]);
    level = (level > 32'(SUM_BIAS)) ? level - 32'(SUM_BIAS) : 32'd0;
    if (dac_variant) begin
      if (level > 32'(CLAMP_10BIT)) level = 32'(CLAMP_10BIT);
      return {code, 2'b00, level[9:0], 2'b00};
    end
    if (level > 32'(CLAMP_8BIT)) level = 32'(CLAMP_8BIT);
    return {5'b00000, code, 1'b0, level[7:0]};
  endfunction

  // Advance the predicted state by one accepted item and return its result.
  task automatic model_item(input mode_t mode, input logic [1:0] ch, input logic [15:0] val,
                            output dac_result_t res);
    logic       inv;
    logic [5:0] frame_len;
    int         msb;
    inv       = dac_variant;
    frame_len = inv ? FRAME_TICKS_V1 : FRAME_TICKS_V0;
    msb       = inv ? MSB_BIT_V1 : MSB_BIT_V0;
    res       = '0;
    case (mode)
      MODE_TICK: begin
        if (frame_step < frame_len) begin
          if (frame_step[0]) begin
            pin_clock = inv;
          end else begin
            // A new frame loads the next channel in the scan.
            if (frame_step == 6'd0) begin
              frame_shift  = frame_word(scan_channel);
              scan_channel = scan_channel + 2'd1;
              pin_frame    = 1'b1;
              frames_started++;
            end
            pin_data    = frame_shift[msb] ^ inv;
            frame_shift = frame_shift << 1;
            pin_clock   = ~inv;
          end
          frame_step = frame_step + 6'd1;
        end else begin
          // Closing tick.
          pin_frame  = 1'b0;
          pin_clock  = 1'b0;
          frame_step = 6'd0;
        end
      end
      MODE_WRITE: begin
        stored_value[ch] = inv ? val : {2'b00, val[15:2]};
      end
      MODE_READ: begin
        res.read_value = inv ? stored_value[ch] : {stored_value[ch][13:0], 2'b00};
      end
      default: begin
      end
    endcase
    res.clock_pin = pin_clock;
    res.data_pin  = pin_data;
    res.frame_pin = pin_frame;
  endtask

  // Offer one input transaction, wait for it to be taken, and queue what it should produce.
  task automatic send_item(input mode_t mode, input logic [1:0] ch, input logic [15:0] val,
                           input logic fixed, input dac_result_t want);
    dac_result_t res;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, val, ch, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_item(mode, ch, val, res);
    pending_results.push_back(fixed ? want : res);
    items_sent++;
  endtask

  // Values that hit the extremes and the bias and clamp boundaries.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       return 16'($urandom_range(0, 16'hFFFF));
      2:       return 16'($urandom_range(0, 600));
      default: return 16'($urandom_range(900, 1200));
    endcase
  endfunction

  // Mostly ticks so that frames run through, with writes, reads and unused modes mixed in.
  task automatic random_item();
    int         pick;
    logic [1:0] ch;
    pick = $urandom_range(0, 99);
    ch   = 2'($urandom_range(0, 3));
    if (pick < 72) send_item(MODE_TICK, ch, pick_value(), 1'b0, '0);
    else if (pick < 84) send_item(MODE_WRITE, ch, pick_value(), 1'b0, '0);
    else if (pick < 96) send_item(MODE_READ, ch, pick_value(), 1'b0, '0);
    else send_item(MODE_NONE, ch, pick_value(), 1'b0, '0);
  endtask

  // Stop offering items and let every expected result come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write followed by a read back; only called while the block is idle.
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== val) begin
      $error("prdata expected %h got %h", val, cfg_prdata);
      error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_VARIANT) dac_variant = val[0];
    else dac_offset[idx - REG_OFFSET0] = val[7:0];
    // Leave the port idle before the next access.
    @(posedge clk);
  endtask

  initial begin
    int         ph;
    int         i;
    int         target;
    logic       next_variant;
    logic [7:0] next_offset [4];

    dac_variant  = 1'b0;
    frame_step   = '0;
    scan_channel = '0;
    frame_shift  = '0;
    pin_clock    = 1'b0;
    pin_data     = 1'b0;
    pin_frame    = 1'b1;
    for (i = 0; i < 4; i++) begin
      dac_offset[i]   = OFFSET_RESET;
      stored_value[i] = '0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings, with light idling on both sides.
    src_gap_pct    = 15;
    sink_stall_pct = 15;
    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].chan, DIRECTED_ROWS[i].value,
                DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
    end

    // Random phases, each under its own register setting.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          next_variant = 1'b0;
          for (i = 0; i < 4; i++) next_offset[i] = 8'd0;
        end
        1: begin
          next_variant = 1'b0;
          for (i = 0; i < 4; i++) next_offset[i] = 8'd255;
        end
        2: begin
          next_variant = 1'b1;
          for (i = 0; i < 4; i++) next_offset[i] = OFFSET_RESET;
        end
        3: begin
          next_variant = 1'b1;
          for (i = 0; i < 4; i++) next_offset[i] = i[0] ? 8'd255 : 8'd0;
        end
        4: begin
          next_variant = 1'b0;
          for (i = 0; i < 4; i++) next_offset[i] = 8'($urandom_range(0, 255));
        end
        default: begin
          next_variant = 1'($urandom_range(0, 1));
          for (i = 0; i < 4; i++) begin
            next_offset[i] = $urandom_range(0, 1) ? 8'($urandom_range(96, 160))
                                                  : 8'($urandom_range(0, 255));
          end
        end
      endcase

      // Leaving the long frame past the short frame's length forces an early closing tick.
      if (dac_variant && !next_variant) begin
        target = $urandom_range(FRAME_TICKS_V0, FRAME_TICKS_V1);
        while (frame_step != target) send_item(MODE_TICK, 2'd0, 16'h0000, 1'b0, '0);
      end
      drain();

      write_reg(REG_VARIANT, {31'd0, next_variant});
      for (i = 0; i < 4; i++) write_reg(reg_idx_t'(REG_OFFSET0 + i), {24'd0, next_offset[i]});

      // The last phase runs at full rate on both sides.
      if (ph == NUM_PHASES - 1) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct    = $urandom_range(0, 2) * 12;
        sink_stall_pct = $urandom_range(0, 2) * 12;
      end
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (10) @(posedge clk);

    $display("tb: %0d input transactions, %0d results checked, %0d frames started",
             items_sent, results_seen, frames_started);
    $display("tb: %0d register settings applied, %0d errors", NUM_PHASES + 1, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
